@@ rtl/core/nnd_pkg.sv @@
// shared types, register codes and helpers for the nearest-neighbor rgb565 downscaler
package nnd_pkg;

  localparam int CFG_W   = 11;  // configuration register width
  localparam int CFG_IDX = 2;   // configuration index width
  localparam int POS_W   = 10;  // destination position field width
  localparam int LEVEL_W = 16;  // q0.16 channel level width

  localparam logic [CFG_IDX-1:0] REG_SOURCE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX-1:0] REG_SOURCE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX-1:0] REG_TARGET_WIDTH  = 2'd2;
  localparam logic [CFG_IDX-1:0] REG_TARGET_HEIGHT = 2'd3;

  localparam logic [CFG_W-1:0] RST_SOURCE_WIDTH  = 11'd320;
  localparam logic [CFG_W-1:0] RST_SOURCE_HEIGHT = 11'd240;
  localparam logic [CFG_W-1:0] RST_TARGET_WIDTH  = 11'd96;
  localparam logic [CFG_W-1:0] RST_TARGET_HEIGHT = 11'd96;

  // selection outcome for the pixel in the input register
  typedef struct packed {
    logic             hit;
    logic [POS_W-1:0] column;
    logic [POS_W-1:0] row;
    logic             last;
  } nnd_sel_t;

  // round(v * 65536 / 255): 65536 = 255 * 257 + 1, so the quotient is
  // 257 * v plus one when v + 127 reaches 255, i.e. when v >= 128
  function automatic logic [LEVEL_W-1:0] q16_level(input logic [7:0] v);
    logic [LEVEL_W-1:0] rep;
    rep = {v, v};
    return rep + LEVEL_W'(v[7]);
  endfunction

endpackage

@@ rtl/core/nnd_cfg.sv @@
// configuration registers with size clamping for the downscaler
module nnd_cfg #(
  parameter int MAX_DIM = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [nnd_pkg::CFG_IDX-1:0]   cfg_index,
  input  logic [nnd_pkg::CFG_W-1:0]     cfg_data,
  output logic [$clog2(MAX_DIM+1)-1:0]  src_w,
  output logic [$clog2(MAX_DIM+1)-1:0]  src_h,
  output logic [$clog2(MAX_DIM+1)-1:0]  dst_w,
  output logic [$clog2(MAX_DIM+1)-1:0]  dst_h
);

  localparam int CW = $clog2(MAX_DIM + 1);
  localparam int EW = (CW > nnd_pkg::CFG_W) ? CW : nnd_pkg::CFG_W;

  logic [nnd_pkg::CFG_W-1:0] source_width;
  logic [nnd_pkg::CFG_W-1:0] source_height;
  logic [nnd_pkg::CFG_W-1:0] target_width;
  logic [nnd_pkg::CFG_W-1:0] target_height;
  logic [CW-1:0]             tw_lim;
  logic [CW-1:0]             th_lim;

  // zero acts as one, anything above the maximum acts as the maximum
  function automatic logic [CW-1:0] clamp_dim(input logic [nnd_pkg::CFG_W-1:0] v);
    logic [EW-1:0] ve;
    ve = EW'(v);
    if (ve == '0) begin
      return CW'(1);
    end else if (ve > EW'(MAX_DIM)) begin
      return CW'(MAX_DIM);
    end else begin
      return CW'(ve);
    end
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      source_width  <= nnd_pkg::RST_SOURCE_WIDTH;
      source_height <= nnd_pkg::RST_SOURCE_HEIGHT;
      target_width  <= nnd_pkg::RST_TARGET_WIDTH;
      target_height <= nnd_pkg::RST_TARGET_HEIGHT;
    end else if (cfg_write) begin
      case (cfg_index)
        nnd_pkg::REG_SOURCE_WIDTH:  source_width  <= cfg_data;
        nnd_pkg::REG_SOURCE_HEIGHT: source_height <= cfg_data;
        nnd_pkg::REG_TARGET_WIDTH:  target_width  <= cfg_data;
        nnd_pkg::REG_TARGET_HEIGHT: target_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    src_w  = clamp_dim(source_width);
    src_h  = clamp_dim(source_height);
    tw_lim = clamp_dim(target_width);
    th_lim = clamp_dim(target_height);
    // no upscaling: target never exceeds source
    dst_w  = (tw_lim > src_w) ? src_w : tw_lim;
    dst_h  = (th_lim > src_h) ? src_h : th_lim;
  end

endmodule

@@ rtl/core/nnd_select.sv @@
// raster counters and running products that pick the nearest source pixel
module nnd_select #(
  parameter int MAX_DIM = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,
  input  logic [$clog2(MAX_DIM+1)-1:0]  src_w,
  input  logic [$clog2(MAX_DIM+1)-1:0]  src_h,
  input  logic [$clog2(MAX_DIM+1)-1:0]  dst_w,
  input  logic [$clog2(MAX_DIM+1)-1:0]  dst_h,
  output nnd_pkg::nnd_sel_t             sel
);

  localparam int CW   = $clog2(MAX_DIM + 1);
  localparam int PW   = 2 * CW;
  localparam int SUMW = PW + 1;
  localparam int XW   = (CW > nnd_pkg::POS_W) ? CW : nnd_pkg::POS_W;

  logic [CW-1:0] src_col, src_col_next;
  logic [CW-1:0] src_row, src_row_next;
  logic [CW-1:0] dst_col, dst_col_next;
  logic [CW-1:0] dst_row, dst_row_next;
  logic [PW-1:0] col_src, col_src_next;   // src_col * dst_w
  logic [PW-1:0] col_tgt, col_tgt_next;   // dst_col * src_w
  logic [PW-1:0] row_src, row_src_next;   // src_row * dst_h
  logic [PW-1:0] row_tgt, row_tgt_next;   // dst_row * src_h

  logic          col_hit;
  logic          row_hit;
  logic          col_end;
  logic          row_end;
  logic [XW-1:0] col_ext;
  logic [XW-1:0] row_ext;

  always_comb begin
    // destination c sits in source column sc when c*SW < (sc+1)*DW
    col_hit = (dst_col < dst_w) &&
              (SUMW'(col_tgt) < SUMW'(col_src) + SUMW'(dst_w));
    row_hit = (dst_row < dst_h) &&
              (SUMW'(row_tgt) < SUMW'(row_src) + SUMW'(dst_h));
    col_end = src_col >= src_w - CW'(1);
    row_end = src_row >= src_h - CW'(1);

    col_ext    = XW'(dst_col);
    row_ext    = XW'(dst_row);
    sel.hit    = col_hit && row_hit;
    sel.column = col_ext[nnd_pkg::POS_W-1:0];
    sel.row    = row_ext[nnd_pkg::POS_W-1:0];
    sel.last   = (dst_row == dst_h - CW'(1)) && (dst_col == dst_w - CW'(1));

    src_col_next = src_col;
    src_row_next = src_row;
    dst_col_next = dst_col;
    dst_row_next = dst_row;
    col_src_next = col_src;
    col_tgt_next = col_tgt;
    row_src_next = row_src;
    row_tgt_next = row_tgt;

    if (col_hit) begin
      dst_col_next = dst_col + CW'(1);
      col_tgt_next = col_tgt + PW'(src_w);
    end

    if (col_end) begin
      src_col_next = '0;
      dst_col_next = '0;
      col_src_next = '0;
      col_tgt_next = '0;
      if (row_hit) begin
        dst_row_next = dst_row + CW'(1);
        row_tgt_next = row_tgt + PW'(src_h);
      end
      if (row_end) begin
        src_row_next = '0;
        dst_row_next = '0;
        row_src_next = '0;
        row_tgt_next = '0;
      end else begin
        src_row_next = src_row + CW'(1);
        row_src_next = row_src + PW'(dst_h);
      end
    end else begin
      src_col_next = src_col + CW'(1);
      col_src_next = col_src + PW'(dst_w);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      src_col <= '0;
      src_row <= '0;
      dst_col <= '0;
      dst_row <= '0;
      col_src <= '0;
      col_tgt <= '0;
      row_src <= '0;
      row_tgt <= '0;
    end else if (step) begin
      src_col <= src_col_next;
      src_row <= src_row_next;
      dst_col <= dst_col_next;
      dst_row <= dst_row_next;
      col_src <= col_src_next;
      col_tgt <= col_tgt_next;
      row_src <= row_src_next;
      row_tgt <= row_tgt_next;
    end
  end

`ifndef SYNTHESIS
  a_hold_when_idle: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(src_col) && $stable(src_row) && $stable(dst_col) && $stable(dst_row))
    else $error("selection counters moved without a step");

  a_line_wrap: assert property (@(posedge clk) disable iff (rst)
    step && col_end |=> src_col == '0 && dst_col == '0 && col_src == '0 && col_tgt == '0)
    else $error("column state not cleared at end of line");

  a_col_advance: assert property (@(posedge clk) disable iff (rst)
    step && !col_end |=> src_col == $past(src_col) + CW'(1)
                         && col_src == $past(col_src) + PW'($past(dst_w)))
    else $error("source column or its product did not advance");
`endif

endmodule

@@ rtl/core/nearest_neighbor_rgb565_downscaler_core.sv @@
// top level of the nearest-neighbor rgb565 downscaler with q0.16 channel output
//
//   channel  direction  handshake            payload
//   in       sink       in_valid/in_ready    pixel_rgb565
//   out      source     out_valid/out_ready  red/green/blue_level, out_column, out_row,
//                                            frame_last
//   cfg      sink       cfg_write            cfg_index, cfg_data
//
// one item per clock when not stalled; selected pixels pass the input and result registers
// the pace is set by the input register feeding the result register, nothing iterates
// pixels that fall between selected positions only advance the counters and give no result
// rst clears the counters, products, valid flags and loads the default 320x240 -> 96x96 sizes
// a stalled result holds in the output register; the input register keeps accepting as long
// as its own item can move on, so in_ready follows out_ready through one gate
module nearest_neighbor_rgb565_downscaler_core #(
  parameter int MAX_DIM = 1024
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration
  input  logic                              cfg_write,
  input  logic [nnd_pkg::CFG_IDX-1:0]       cfg_index,
  input  logic [nnd_pkg::CFG_W-1:0]         cfg_data,
  // source pixels
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [15:0]                       pixel_rgb565,
  // destination pixels
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [nnd_pkg::LEVEL_W-1:0]       red_level,
  output logic [nnd_pkg::LEVEL_W-1:0]       green_level,
  output logic [nnd_pkg::LEVEL_W-1:0]       blue_level,
  output logic [nnd_pkg::POS_W-1:0]         out_column,
  output logic [nnd_pkg::POS_W-1:0]         out_row,
  output logic                              frame_last
);

  localparam int CW = $clog2(MAX_DIM + 1);

  // effective sizes after clamping
  logic [CW-1:0]     src_w;
  logic [CW-1:0]     src_h;
  logic [CW-1:0]     dst_w;
  logic [CW-1:0]     dst_h;

  // input register
  logic              s1_valid;
  logic [15:0]       s1_pixel;
  logic              s1_go;
  logic              out_free;

  nnd_pkg::nnd_sel_t sel;

  logic [7:0]        red8;
  logic [7:0]        green8;
  logic [7:0]        blue8;

  nnd_cfg #(
    .MAX_DIM (MAX_DIM)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .src_w     (src_w),
    .src_h     (src_h),
    .dst_w     (dst_w),
    .dst_h     (dst_h)
  );

  nnd_select #(
    .MAX_DIM (MAX_DIM)
  ) u_select (
    .clk   (clk),
    .rst   (rst),
    .step  (s1_go),
    .src_w (src_w),
    .src_h (src_h),
    .dst_w (dst_w),
    .dst_h (dst_h),
    .sel   (sel)
  );

  // the result register can take a new value when empty or being drained
  assign out_free = !out_valid || out_ready;
  // the pixel in the input register is consumed every time the result side can take it,
  // whether or not it is selected
  assign s1_go    = s1_valid && out_free;
  assign in_ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_pixel <= pixel_rgb565;
    end
  end

  // unpack 5/6/5 fields to 8-bit levels
  always_comb begin
    red8   = {s1_pixel[15:11], 3'b000};
    green8 = {s1_pixel[10:5], 2'b00};
    blue8  = {s1_pixel[4:0], 3'b000};
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid && sel.hit;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && sel.hit) begin
      red_level   <= nnd_pkg::q16_level(red8);
      green_level <= nnd_pkg::q16_level(green8);
      blue_level  <= nnd_pkg::q16_level(blue8);
      out_column  <= sel.column;
      out_row     <= sel.row;
      frame_last  <= sel.last;
    end
  end

`ifndef SYNTHESIS
  a_load_from_hit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_valid && sel.hit))
    else $error("result appeared without a selected pixel");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> in_ready)
    else $error("input refused while the input register is empty");

  a_stall_holds_pixel: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !out_free |=> s1_valid && $stable(s1_pixel))
    else $error("pending pixel lost during an output stall");
`endif

endmodule

@@ tb/tb_top.sv @@
// self-checking testbench for the nearest-neighbor rgb565 downscaler core
module tb_top;

  localparam int MAX_DIM      = 1024;
  localparam int LIMIT        = 1_000_000;  // cycle budget for the whole run
  localparam int HOLD_CYCLES  = 300;        // long receiver hold-off that backs up the input
  localparam int RANDOM_ITEMS = 200;        // random source pixels before the run winds down
  localparam int WIDE_ITEMS   = 256;        // pixels sent on the widest line
  localparam int DRAIN_CYCLES = 6;          // pipeline is two deep, give it a little more
  localparam int MAX_REPORTS  = 10;

  // one destination pixel as the block presents it
  typedef struct packed {
    logic [nnd_pkg::LEVEL_W-1:0] red;
    logic [nnd_pkg::LEVEL_W-1:0] green;
    logic [nnd_pkg::LEVEL_W-1:0] blue;
    logic [nnd_pkg::POS_W-1:0]   column;
    logic [nnd_pkg::POS_W-1:0]   row;
    logic                        last;
  } dst_pixel_t;

  // dut signals, every input known from time zero
  logic                        clk          = 1'b0;
  logic                        rst          = 1'b1;
  logic                        cfg_write    = 1'b0;
  logic [nnd_pkg::CFG_IDX-1:0] cfg_index    = nnd_pkg::REG_SOURCE_WIDTH;
  logic [nnd_pkg::CFG_W-1:0]   cfg_data     = '0;
  logic                        in_valid     = 1'b0;
  logic                        in_ready;
  logic [15:0]                 pixel_rgb565 = '0;
  logic                        out_valid;
  logic                        out_ready    = 1'b0;
  logic [nnd_pkg::LEVEL_W-1:0] red_level;
  logic [nnd_pkg::LEVEL_W-1:0] green_level;
  logic [nnd_pkg::LEVEL_W-1:0] blue_level;
  logic [nnd_pkg::POS_W-1:0]   out_column;
  logic [nnd_pkg::POS_W-1:0]   out_row;
  logic                        frame_last;

  // local copy of the size registers, starts at the reset defaults
  logic [nnd_pkg::CFG_W-1:0] reg_sw = nnd_pkg::RST_SOURCE_WIDTH;
  logic [nnd_pkg::CFG_W-1:0] reg_sh = nnd_pkg::RST_SOURCE_HEIGHT;
  logic [nnd_pkg::CFG_W-1:0] reg_dw = nnd_pkg::RST_TARGET_WIDTH;
  logic [nnd_pkg::CFG_W-1:0] reg_dh = nnd_pkg::RST_TARGET_HEIGHT;

  // scan position and running products of the downscaler
  logic [31:0] src_col, src_row, dst_col, dst_row;
  logic [31:0] col_src_prod, col_dst_prod, row_src_prod, row_dst_prod;

  dst_pixel_t  expected_pixels[$];  // selected pixels still to come out
  logic [15:0] pending_pixels[$];   // source pixels not yet offered

  int unsigned items_queued    = 0;
  int unsigned items_accepted  = 0;
  int unsigned results_checked = 0;
  int unsigned frames_seen     = 0;
  int unsigned fail_count      = 0;
  int unsigned cycle_count     = 0;
  int unsigned phase_count     = 0;
  int          tx_gap          = 0;
  int          rx_gap          = 0;
  int          hold_count      = 0;
  bit          steady          = 1'b0;  // no random idle gaps on either side while set
  bit          hold_request    = 1'b0;
  bit          hold_done       = 1'b0;

  nearest_neighbor_rgb565_downscaler_core #(.MAX_DIM(MAX_DIM)) u_top (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // a zero size acts as one, anything past the maximum acts as the maximum
  function automatic logic [31:0] eff_dim(input logic [nnd_pkg::CFG_W-1:0] v);
    if (v == '0) return 32'd1;
    if (v > MAX_DIM) return 32'(MAX_DIM);
    return 32'(v);
  endfunction

  // round(v * 65536 / 255) in q0.16
  function automatic logic [nnd_pkg::LEVEL_W-1:0] to_level(input logic [7:0] v);
    logic [31:0] q;
    q = (32'(v) * 32'd65536 + 32'd127) / 32'd255;
    return q[nnd_pkg::LEVEL_W-1:0];
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady) return 0;
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 24);
  endfunction

  // mostly in the given span, sometimes a size at or past the edges
  function automatic logic [nnd_pkg::CFG_W-1:0] random_dim(input int lo, input int hi);
    if ($urandom_range(0, 99) < 85) return nnd_pkg::CFG_W'($urandom_range(lo, hi));
    case ($urandom_range(0, 6))
      0:       return '0;
      1:       return nnd_pkg::CFG_W'(1);
      2:       return nnd_pkg::CFG_W'(1023);
      3:       return nnd_pkg::CFG_W'(1024);
      4:       return nnd_pkg::CFG_W'(1025);
      5:       return nnd_pkg::CFG_W'($urandom);
      default: return '1;
    endcase
  endfunction

  // advance the scan by one source pixel and note the pixel if it is selected
  task automatic predict_downscale(input logic [15:0] px);
    logic [31:0] sw, sh, dw, dh;
    logic        row_hit, col_hit;
    dst_pixel_t  p;
    sw = eff_dim(reg_sw);
    sh = eff_dim(reg_sh);
    dw = eff_dim(reg_dw);
    dh = eff_dim(reg_dh);
    // the target never exceeds the source
    if (dw > sw) dw = sw;
    if (dh > sh) dh = sh;
    // selected when the next destination position falls inside this source pixel
    row_hit = (dst_row < dh) && (row_dst_prod < row_src_prod + dh);
    col_hit = (dst_col < dw) && (col_dst_prod < col_src_prod + dw);
    if (row_hit && col_hit) begin
      p.red    = to_level({px[15:11], 3'b000});
      p.green  = to_level({px[10:5], 2'b00});
      p.blue   = to_level({px[4:0], 3'b000});
      p.column = dst_col[nnd_pkg::POS_W-1:0];
      p.row    = dst_row[nnd_pkg::POS_W-1:0];
      p.last   = (dst_row == dh - 1) && (dst_col == dw - 1);
      expected_pixels.push_back(p);
    end
    if (col_hit) begin
      dst_col      = dst_col + 1;
      col_dst_prod = col_dst_prod + sw;
    end
    // end of line, and end of frame below it; a counter past a shrunk size ends here too
    if (src_col + 1 >= sw) begin
      src_col      = '0;
      dst_col      = '0;
      col_src_prod = '0;
      col_dst_prod = '0;
      if (row_hit) begin
        dst_row      = dst_row + 1;
        row_dst_prod = row_dst_prod + sh;
      end
      if (src_row + 1 >= sh) begin
        src_row      = '0;
        dst_row      = '0;
        row_src_prod = '0;
        row_dst_prod = '0;
      end else begin
        src_row      = src_row + 1;
        row_src_prod = row_src_prod + dh;
      end
    end else begin
      src_col      = src_col + 1;
      col_src_prod = col_src_prod + dw;
    end
  endtask

  // register write, only issued while the block is idle
  task automatic write_reg(input logic [nnd_pkg::CFG_IDX-1:0] idx,
                           input logic [nnd_pkg::CFG_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      nnd_pkg::REG_SOURCE_WIDTH:  reg_sw = val;
      nnd_pkg::REG_SOURCE_HEIGHT: reg_sh = val;
      nnd_pkg::REG_TARGET_WIDTH:  reg_dw = val;
      nnd_pkg::REG_TARGET_HEIGHT: reg_dh = val;
      default: ;
    endcase
  endtask

  task automatic send(input logic [15:0] px);
    pending_pixels.push_back(px);
    items_queued++;
  endtask

  // random pixels with the all-zero and all-one words mixed in
  task automatic send_random(input int count);
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 19))
        0:       send(16'h0000);
        1:       send(16'hFFFF);
        default: send(16'($urandom_range(0, 65535)));
      endcase
    end
  endtask

  // every item accepted and every result out, then let non-selected pixels drain
  task automatic wait_idle();
    while (items_accepted != items_queued || expected_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    phase_count++;
  endtask

  // source side driver: offers queued pixels, predicts on each accepted one
  always @(posedge clk) begin
    if (rst) begin
      in_valid     <= 1'b0;
      tx_gap       = 0;
      src_col      = '0;
      src_row      = '0;
      dst_col      = '0;
      dst_row      = '0;
      col_src_prod = '0;
      col_dst_prod = '0;
      row_src_prod = '0;
      row_dst_prod = '0;
    end else begin
      if (in_valid && in_ready) begin
        predict_downscale(pixel_rgb565);
        items_accepted++;
      end
      // valid and payload only change once the current item is gone
      if (!in_valid || in_ready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (pending_pixels.size() != 0) begin
          in_valid     <= 1'b1;
          pixel_rgb565 <= pending_pixels.pop_front();
          tx_gap       = idle_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result side ready: random gaps plus one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      rx_gap    = 0;
    end else if (hold_request && !hold_done) begin
      out_ready <= 1'b0;
      hold_count++;
      if (hold_count >= HOLD_CYCLES) hold_done = 1'b1;
    end else if (rx_gap > 0) begin
      out_ready <= 1'b0;
      rx_gap--;
    end else begin
      out_ready <= 1'b1;
      rx_gap    = idle_gap();
    end
  end

  // result monitor: each accepted result against the oldest expected pixel
  always @(posedge clk) begin : monitor
    dst_pixel_t want, got;
    if (!rst && out_valid && out_ready) begin
      got.red    = red_level;
      got.green  = green_level;
      got.blue   = blue_level;
      got.column = out_column;
      got.row    = out_row;
      got.last   = frame_last;
      if (expected_pixels.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("unexpected result: r=%0d g=%0d b=%0d col=%0d row=%0d last=%0d",
                   got.red, got.green, got.blue, got.column, got.row, got.last);
      end else begin
        want = expected_pixels.pop_front();
        results_checked++;
        if (got.last) frames_seen++;
        if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
            got.column !== want.column || got.row !== want.row || got.last !== want.last) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("mismatch: want %0d/%0d/%0d c%0d r%0d l%0d got %0d/%0d/%0d c%0d r%0d l%0d",
                     want.red, want.green, want.blue, want.column, want.row, want.last,
                     got.red, got.green, got.blue, got.column, got.row, got.last);
        end
      end
    end
  end

  // hard stop if the block hangs
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_pixels.size());
      $display("tb_top NOT OK");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned rand_items;
    int          n;
    logic [31:0] frame;
    logic [nnd_pkg::CFG_W-1:0] sw_v, sh_v;
    rand_items = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // default 320x240 -> 96x96, first columns of the first line
    send(16'h0000);
    send(16'hFFFF);
    send(16'hF800);
    send(16'h07E0);
    wait_idle();

    // identity 2x2 written mid-line, the old column count is already past the new width
    write_reg(nnd_pkg::REG_SOURCE_WIDTH, nnd_pkg::CFG_W'(2));
    write_reg(nnd_pkg::REG_SOURCE_HEIGHT, nnd_pkg::CFG_W'(2));
    write_reg(nnd_pkg::REG_TARGET_WIDTH, nnd_pkg::CFG_W'(2));
    write_reg(nnd_pkg::REG_TARGET_HEIGHT, nnd_pkg::CFG_W'(2));
    send(16'h001F);
    send(16'h8410);
    send(16'h7BEF);
    send(16'hAAAA);
    wait_idle();

    // zero sizes act as 1x1, every pixel ends a frame
    write_reg(nnd_pkg::REG_SOURCE_WIDTH, '0);
    write_reg(nnd_pkg::REG_SOURCE_HEIGHT, '0);
    write_reg(nnd_pkg::REG_TARGET_WIDTH, '0);
    write_reg(nnd_pkg::REG_TARGET_HEIGHT, '0);
    send(16'h5555);
    send(16'h0821);
    send(16'hFFFF);
    wait_idle();

    // target bigger than source, height register at its top value
    write_reg(nnd_pkg::REG_SOURCE_WIDTH, nnd_pkg::CFG_W'(3));
    write_reg(nnd_pkg::REG_SOURCE_HEIGHT, nnd_pkg::CFG_W'(2));
    write_reg(nnd_pkg::REG_TARGET_WIDTH, nnd_pkg::CFG_W'(7));
    write_reg(nnd_pkg::REG_TARGET_HEIGHT, '1);
    send_random(6);
    wait_idle();

    // plain downscale 4x2 -> 3x1
    write_reg(nnd_pkg::REG_SOURCE_WIDTH, nnd_pkg::CFG_W'(4));
    write_reg(nnd_pkg::REG_SOURCE_HEIGHT, nnd_pkg::CFG_W'(2));
    write_reg(nnd_pkg::REG_TARGET_WIDTH, nnd_pkg::CFG_W'(3));
    write_reg(nnd_pkg::REG_TARGET_HEIGHT, nnd_pkg::CFG_W'(1));
    send_random(8);
    wait_idle();

    // widest line: oversized width clamps to the maximum, one line per frame, left mid-line
    write_reg(nnd_pkg::REG_SOURCE_WIDTH, '1);
    write_reg(nnd_pkg::REG_SOURCE_HEIGHT, '0);
    write_reg(nnd_pkg::REG_TARGET_WIDTH, nnd_pkg::CFG_W'(1030));
    write_reg(nnd_pkg::REG_TARGET_HEIGHT, nnd_pkg::CFG_W'(3));
    send_random(WIDE_ITEMS);
    wait_idle();

    // tallest frame, one pixel per line, runs to the frame end so the scan starts clean
    write_reg(nnd_pkg::REG_SOURCE_WIDTH, nnd_pkg::CFG_W'(1));
    write_reg(nnd_pkg::REG_SOURCE_HEIGHT, nnd_pkg::CFG_W'(MAX_DIM));
    write_reg(nnd_pkg::REG_TARGET_WIDTH, nnd_pkg::CFG_W'(1));
    write_reg(nnd_pkg::REG_TARGET_HEIGHT, nnd_pkg::CFG_W'(MAX_DIM));
    send_random(MAX_DIM);
    wait_idle();

    // random phases: whole frames with random content, often ending mid-frame
    for (int ph = 0; rand_items < RANDOM_ITEMS; ph++) begin
      sw_v = random_dim(1, 16);
      sh_v = random_dim(1, 10);
      if (ph == 0 || $urandom_range(0, 4) != 0)
        write_reg(nnd_pkg::REG_SOURCE_WIDTH, sw_v);
      if (ph == 0 || $urandom_range(0, 4) != 0)
        write_reg(nnd_pkg::REG_SOURCE_HEIGHT, sh_v);
      if (ph == 0 || $urandom_range(0, 4) != 0)
        write_reg(nnd_pkg::REG_TARGET_WIDTH,
                  random_dim(0, (eff_dim(reg_sw) > 16 ? 16 : eff_dim(reg_sw)) + 3));
      if (ph == 0 || $urandom_range(0, 4) != 0)
        write_reg(nnd_pkg::REG_TARGET_HEIGHT,
                  random_dim(0, (eff_dim(reg_sh) > 10 ? 10 : eff_dim(reg_sh)) + 3));
      frame = eff_dim(reg_sw) * eff_dim(reg_sh);
      if (frame <= 240) begin
        n = frame * $urandom_range(1, 3);
        if ($urandom_range(0, 1) != 0) n += $urandom_range(0, frame - 1);
      end else begin
        n = $urandom_range(20, 150);
      end
      steady = ($urandom_range(0, 5) == 0);
      // one phase with the receiver parked while the sender keeps offering
      if (ph == 0) begin
        steady       = 1'b1;
        hold_request = 1'b1;
        if (n < 80) n = 80;
      end
      send_random(n);
      wait_idle();
      rand_items += n;
    end
    steady = 1'b0;

    if (expected_pixels.size() != 0) begin
      fail_count += expected_pixels.size();
      $display("%0d expected results never arrived", expected_pixels.size());
    end
    $display("summary: %0d source pixels over %0d phases, %0d selected pixels checked",
             items_accepted, phase_count, results_checked);
    $display("summary: %0d frame ends seen, %0d failures", frames_seen, fail_count);
    if (fail_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
